// ----- design/lobm_pkg.sv -----
// Package for the limit order book matcher: table size, result codes and
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
package lobm_pkg;

	localparam int BOOK_ENTRIES = 32;
	localparam int IDX_W = $clog2(BOOK_ENTRIES);

	localparam logic [1:0] RES_TRADE   = 2'd0;
	localparam logic [1:0] RES_DONE    = 2'd1;
	localparam logic [1:0] RES_CANCEL  = 2'd2;
	localparam logic [1:0] RES_UNKNOWN = 2'd3;

	localparam logic KIND_NEW    = 1'b0;
	localparam logic KIND_CANCEL = 1'b1;
	localparam logic SIDE_BUY    = 1'b0;
	localparam logic TYPE_LIMIT  = 1'b0;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] aggressor_session;
		logic [31:0] aggressor_id;
		logic [15:0] resting_session;
		logic [31:0] resting_id;
		logic [31:0] trade_price;
		logic [31:0] amount;
		logic [31:0] resting_left;
		logic        book_full;
		logic        last;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the input item
		logic scan_start;  // clear the scan accumulators
		logic scan_step;   // examine one table entry
		logic do_fill;     // apply a fill against the scan winner
		logic do_cancel;   // remove the cancel hit
		logic do_rest;     // write the remainder into the free slot
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_cancel;
		logic scan_last;   // the entry being examined is the last one
		logic fill_ok;     // a crossing entry was found and quantity remains
	} stat_t;

endpackage

// ----- design/lobm_datapath.sv -----
// Datapath of the order matcher: order table, sequential scan unit, fill
// arithmetic and result register. Depends on lobm_pkg.
`timescale 1ns / 1ps
module lobm_datapath import lobm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	output stat_t         stat,
	input  logic          in_kind,
	input  logic          in_side,
	input  logic          in_type,
	input  logic [31:0]   in_price,
	input  logic [31:0]   in_qty,
	input  logic [15:0]   in_session,
	input  logic [31:0]   in_id,
	output result_t       res
);

	logic [BOOK_ENTRIES-1:0] valid_q;
	logic                    side_q  [BOOK_ENTRIES];
	logic [31:0]             price_q [BOOK_ENTRIES];
	logic [31:0]             remain_q[BOOK_ENTRIES];
	logic [15:0]             sess_q  [BOOK_ENTRIES];
	logic [31:0]             ident_q [BOOK_ENTRIES];
	logic [31:0]             arrive_q[BOOK_ENTRIES];
	logic [31:0]             arrival_counter_q;

	logic        kind_q, side_in_q, type_q;
	logic [31:0] price_in_q, rem_q, id_q;
	logic [15:0] sess_in_q;

	logic [IDX_W-1:0] scan_idx_q, best_idx_q, free_idx_q;
	logic             best_found_q, free_found_q;
	logic [31:0]      best_price_q, best_age_q;

	logic [IDX_W-1:0] cur;
	logic [31:0]      cur_age, fill, best_rem;
	logic             cand, better, crosses;

	assign cur     = scan_idx_q;
	assign cur_age = arrival_counter_q - arrive_q[cur];

	// Candidate test for the entry under the scan pointer.
	always_comb begin
		if (kind_q == KIND_CANCEL) begin
			cand   = valid_q[cur] && sess_q[cur] == sess_in_q && ident_q[cur] == id_q;
			better = !best_found_q || cur_age > best_age_q;
		end else begin
			cand = valid_q[cur] && side_q[cur] != side_in_q;
			if (!best_found_q)
				better = 1'b1;
			else if (price_q[cur] != best_price_q)
				better = (side_in_q == SIDE_BUY) ? price_q[cur] < best_price_q
				                                 : price_q[cur] > best_price_q;
			else
				better = cur_age > best_age_q;
		end
	end

	assign best_rem = remain_q[best_idx_q];
	assign fill     = (rem_q < best_rem) ? rem_q : best_rem;
	assign crosses  = (type_q != TYPE_LIMIT) ||
	                  ((side_in_q == SIDE_BUY) ? best_price_q <= price_in_q
	                                           : best_price_q >= price_in_q);

	assign stat.is_cancel = kind_q;
	assign stat.scan_last = (scan_idx_q == IDX_W'(BOOK_ENTRIES - 1));
	assign stat.fill_ok   = best_found_q && crosses && rem_q != 32'd0;

	// Control state of the table and the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q           <= '0;
			arrival_counter_q <= '0;
			scan_idx_q        <= '0;
			best_found_q      <= 1'b0;
			free_found_q      <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (cand && better)
					best_found_q <= 1'b1;
				if (!valid_q[cur])
					free_found_q <= 1'b1;
			end
			if (cmd.do_fill && best_rem == fill)
				valid_q[best_idx_q] <= 1'b0;
			if (cmd.do_cancel && best_found_q)
				valid_q[best_idx_q] <= 1'b0;
			if (cmd.do_rest && type_q == TYPE_LIMIT && rem_q != 0 && free_found_q) begin
				valid_q[free_idx_q] <= 1'b1;
				arrival_counter_q   <= arrival_counter_q + 32'd1;
			end
		end
	end

	// Payload: input capture, scan winners, table contents and results.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= in_kind;
			side_in_q  <= in_side;
			type_q     <= in_type;
			price_in_q <= in_price;
			rem_q      <= in_qty;
			sess_in_q  <= in_session;
			id_q       <= in_id;
		end
		if (cmd.scan_step) begin
			if (cand && better) begin
				best_idx_q   <= cur;
				best_price_q <= price_q[cur];
				best_age_q   <= cur_age;
			end
			if (!valid_q[cur] && !free_found_q)
				free_idx_q <= cur;
		end
		if (cmd.do_fill) begin
			rem_q                <= rem_q - fill;
			remain_q[best_idx_q] <= best_rem - fill;
			res <= '{RES_TRADE, sess_in_q, id_q, sess_q[best_idx_q], ident_q[best_idx_q],
			         best_price_q, fill, best_rem - fill, 1'b0, 1'b0};
		end
		if (cmd.do_cancel) begin
			res <= best_found_q
			     ? '{RES_CANCEL, sess_in_q, id_q, 16'd0, 32'd0, 32'd0, best_rem, 32'd0,
			         1'b0, 1'b1}
			     : '{RES_UNKNOWN, sess_in_q, id_q, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0,
			         1'b0, 1'b1};
		end
		if (cmd.do_rest) begin
			if (type_q == TYPE_LIMIT && rem_q != 0 && free_found_q) begin
				side_q[free_idx_q]   <= side_in_q;
				price_q[free_idx_q]  <= price_in_q;
				remain_q[free_idx_q] <= rem_q;
				sess_q[free_idx_q]   <= sess_in_q;
				ident_q[free_idx_q]  <= id_q;
				arrive_q[free_idx_q] <= arrival_counter_q;
			end
			res <= '{RES_DONE, sess_in_q, id_q, 16'd0, 32'd0, 32'd0,
			         (type_q == TYPE_LIMIT && rem_q != 0 && free_found_q) ? rem_q : 32'd0,
			         32'd0, type_q == TYPE_LIMIT && rem_q != 0 && !free_found_q, 1'b1};
		end
	end

endmodule

// ----- design/lobm_ctrl.sv -----
// Controller of the order matcher: sequences scans, fills and result
// hand-off. Depends on lobm_pkg.
`timescale 1ns / 1ps
module lobm_ctrl import lobm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_valid,
	output logic  s_ready,
	output logic  m_valid,
	input  logic  m_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_DEC   = 6'b000100,
		ST_FILL  = 6'b001000,
		ST_FINAL = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   m_valid_q;

	assign s_ready = (state_q == ST_IDLE) && !m_valid_q;
	assign m_valid = m_valid_q;

	// Next-state and command decode.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_valid && s_ready) begin
					cmd.load       = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last)
					state_d = ST_DEC;
			end
			ST_DEC: begin
				if (stat.is_cancel) begin
					cmd.do_cancel = 1'b1;
					state_d       = ST_OUT;
				end else if (stat.fill_ok) begin
					cmd.do_fill = 1'b1;
					state_d     = ST_FILL;
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_FILL: begin
				if (!m_valid_q) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_FINAL: begin
				if (!m_valid_q) begin
					cmd.do_rest = 1'b1;
					state_d     = ST_OUT;
				end
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.do_fill || cmd.do_cancel || cmd.do_rest)
				m_valid_q <= 1'b1;
			else if (m_ready)
				m_valid_q <= 1'b0;
		end
	end

endmodule

// ----- design/limit_order_book_matcher_top.sv -----
// Top level of the limit order book matcher: stream ports, controller and
// datapath. Depends on lobm_pkg, lobm_ctrl and lobm_datapath.
//
//   Channel  Dir  Payload
//   s_axis   in   orders and cancels (tdata 112 bits, tuser 3 bits)
//   m_axis   out  trades and closing results (tdata 192 bits, tuser, tlast)
//
// Each table scan examines all BOOK_ENTRIES entries and is followed by a decision
// state; an order makes one scan per fill plus one. Reset clears valid bits and
// the arrival counter. A stalled result holds the matcher before its next fill
// or close.
`timescale 1ns / 1ps
module limit_order_book_matcher_top import lobm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// price, quantity, session, order_id
	input  logic [111:0] s_axis_tdata,
	// kind, side, order_type
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// aggressor_session, aggressor_id, resting_session, resting_id,
	// trade_price, amount, resting_left
	output logic [191:0] m_axis_tdata,
	// result_kind, book_full
	output logic [2:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	cmd_t    cmd;
	stat_t   stat;
	result_t res;

	lobm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	lobm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_kind(s_axis_tuser[0]), .in_side(s_axis_tuser[1]),
		.in_type(s_axis_tuser[2]), .in_price(s_axis_tdata[31:0]),
		.in_qty(s_axis_tdata[63:32]), .in_session(s_axis_tdata[79:64]),
		.in_id(s_axis_tdata[111:80]), .res(res)
	);

	assign m_axis_tdata = {res.resting_left, res.amount, res.trade_price,
	                       res.resting_id, res.resting_session, res.aggressor_id,
	                       res.aggressor_session};
	assign m_axis_tuser = {res.book_full, res.result_kind};
	assign m_axis_tlast = res.last;

endmodule
